// ===== rtl/htok_pkg.sv =====
// ---------------------------------------------------------------------------
// htok_pkg
// Shared types, limits and codes of the request header tokenizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package htok_pkg;

  localparam int METHOD_MAX  = 16;
  localparam int URI_MAX     = 256;
  localparam int VERSION_MAX = 16;
  localparam int NAME_MAX    = 64;
  localparam int VALUE_MAX   = 256;
  localparam int HEADERS_MAX = 32;

  localparam int LIMIT_TOP =
    (URI_MAX > VALUE_MAX ? URI_MAX : VALUE_MAX) > NAME_MAX ?
    (URI_MAX > VALUE_MAX ? URI_MAX : VALUE_MAX) : NAME_MAX;
  localparam int FLEN_W = $clog2((LIMIT_TOP > METHOD_MAX ?
    (LIMIT_TOP > VERSION_MAX ? LIMIT_TOP : VERSION_MAX) :
    (METHOD_MAX > VERSION_MAX ? METHOD_MAX : VERSION_MAX)) + 1);
  localparam int HNUM_W = $clog2(HEADERS_MAX + 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_SP       = 8'd32;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_COLON    = 8'd58;
  localparam logic [7:0] CH_UPPER_LO = 8'd64;
  localparam logic [7:0] CH_UPPER_HI = 8'd91;
  localparam logic [7:0] CH_CASE_OFS = 8'd32;

  localparam logic [3:0] PH_METHOD  = 4'd0;
  localparam logic [3:0] PH_URI     = 4'd1;
  localparam logic [3:0] PH_VERSION = 4'd2;
  localparam logic [3:0] PH_VER_LF  = 4'd3;
  localparam logic [3:0] PH_LINE    = 4'd4;
  localparam logic [3:0] PH_NAME    = 4'd5;
  localparam logic [3:0] PH_VALUE   = 4'd6;
  localparam logic [3:0] PH_VAL_LF  = 4'd7;
  localparam logic [3:0] PH_END_LF  = 4'd8;
  localparam logic [3:0] PH_DONE    = 4'd9;
  localparam logic [3:0] PH_ERROR   = 4'd10;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_METHOD  = 3'd1;
  localparam logic [2:0] KIND_URI     = 3'd2;
  localparam logic [2:0] KIND_VERSION = 3'd3;
  localparam logic [2:0] KIND_NAME    = 3'd4;
  localparam logic [2:0] KIND_VALUE   = 3'd5;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] lower;
    logic       start;
    logic       is_sp;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
  } token_t;

endpackage

// ===== rtl/htok_front.sv =====
// ---------------------------------------------------------------------------
// htok_front
// Input stage: accept a byte, classify it and register the token.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module htok_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            start_request,
  output logic            tok_valid,
  input  logic            tok_ready,
  output htok_pkg::token_t tok
);
  import htok_pkg::*;

  token_t tok_next;

  assign in_ready = !tok_valid || tok_ready;

  always_comb begin
    tok_next.data     = data_byte;
    tok_next.lower    = (data_byte > CH_UPPER_LO && data_byte < CH_UPPER_HI) ?
                        data_byte + CH_CASE_OFS : data_byte;
    tok_next.start    = start_request;
    tok_next.is_sp    = data_byte == CH_SP;
    tok_next.is_cr    = data_byte == CH_CR;
    tok_next.is_lf    = data_byte == CH_LF;
    tok_next.is_colon = data_byte == CH_COLON;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (in_ready) begin
      tok_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok <= tok_next;
    end
  end

endmodule

// ===== rtl/htok_queue.sv =====
// ---------------------------------------------------------------------------
// htok_queue
// Short token queue between the classify stage and the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module htok_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  htok_pkg::token_t wr_tok,
  output logic             rd_valid,
  input  logic             rd_ready,
  output htok_pkg::token_t rd_tok
);
  import htok_pkg::*;

  token_t            slots [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_CW-1:0]   count;
  logic              push;
  logic              pop;

  assign wr_ready = count != Q_CW'(Q_DEPTH);
  assign rd_valid = count != '0;
  assign rd_tok   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= Q_CW'(Q_DEPTH))
    else $error("queue count past depth");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + Q_CW'(1))
    else $error("queue count missed a push");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers apart while empty");

endmodule

// ===== rtl/htok_back.sv =====
// ---------------------------------------------------------------------------
// htok_back
// Parser: advance the field state per token and register the result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module htok_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_ready,
  input  htok_pkg::token_t tok,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       field_kind,
  output logic [7:0]       out_byte,
  output logic             field_end,
  output logic [5:0]       header_index,
  output logic [11:0]      method_sum,
  output logic             truncated,
  output logic [1:0]       status
);
  import htok_pkg::*;

  logic [3:0]        phase, phase_next;
  logic [FLEN_W-1:0] flen, flen_next;
  logic [11:0]       mtot, mtot_next;
  logic [HNUM_W-1:0] hnum, hnum_next;
  logic              err, err_next;

  logic [3:0]        ph;
  logic [FLEN_W-1:0] fl;
  logic [11:0]       mt;
  logic [HNUM_W-1:0] hn;
  logic              er;
  logic              extra;
  logic [12:0]       msum;
  logic [2:0]        kind;
  logic [7:0]        obyte;
  logic              fend;
  logic              trunc;
  logic              pop;

  assign tok_ready = !out_valid || out_ready;
  assign pop       = tok_valid && tok_ready;

  always_comb begin
    ph    = tok.start ? PH_METHOD : phase;
    fl    = tok.start ? '0 : flen;
    mt    = tok.start ? '0 : mtot;
    hn    = tok.start ? '0 : hnum;
    er    = tok.start ? 1'b0 : err;
    extra = hn >= HNUM_W'(HEADERS_MAX);
    msum  = {1'b0, mt} + {5'b0, tok.data};
    phase_next = ph;
    flen_next  = fl;
    mtot_next  = mt;
    hnum_next  = hn;
    err_next   = er;
    kind  = KIND_NONE;
    obyte = tok.data;
    fend  = 1'b0;
    trunc = 1'b0;
    unique case (ph)
      PH_METHOD: begin
        if (tok.is_sp) begin
          fend = 1'b1; flen_next = '0; phase_next = PH_URI;
        end else if (fl < FLEN_W'(METHOD_MAX)) begin
          flen_next = fl + FLEN_W'(1);
          kind      = KIND_METHOD;
          mtot_next = msum[12] ? 12'hfff : msum[11:0];
        end else begin
          trunc = 1'b1;
        end
      end
      PH_URI: begin
        if (tok.is_sp) begin
          fend = 1'b1; flen_next = '0; phase_next = PH_VERSION;
        end else if (fl < FLEN_W'(URI_MAX)) begin
          flen_next = fl + FLEN_W'(1);
          kind      = KIND_URI;
        end else begin
          trunc = 1'b1;
        end
      end
      PH_VERSION: begin
        if (tok.is_cr) begin
          fend = 1'b1; flen_next = '0; phase_next = PH_VER_LF;
        end else if (fl < FLEN_W'(VERSION_MAX)) begin
          flen_next = fl + FLEN_W'(1);
          kind      = KIND_VERSION;
        end else begin
          trunc = 1'b1;
        end
      end
      PH_VER_LF, PH_VAL_LF, PH_END_LF: begin
        if (!tok.is_lf) begin
          err_next = 1'b1; phase_next = PH_ERROR;
        end else if (ph == PH_END_LF) begin
          phase_next = PH_DONE;
        end else begin
          if (ph == PH_VAL_LF && !extra) begin
            hnum_next = hn + HNUM_W'(1);
          end
          flen_next  = '0;
          phase_next = PH_LINE;
        end
      end
      PH_LINE, PH_NAME: begin
        if (ph == PH_LINE && tok.is_cr) begin
          phase_next = PH_END_LF;
        end else begin
          phase_next = PH_NAME;
          if (tok.is_colon) begin
            fend = 1'b1; flen_next = '0; phase_next = PH_VALUE;
          end else if (tok.is_cr) begin
            fend = 1'b1; flen_next = '0; phase_next = PH_VAL_LF;
          end else if (!extra && fl < FLEN_W'(NAME_MAX)) begin
            flen_next = fl + FLEN_W'(1);
            kind      = KIND_NAME;
            obyte     = tok.lower;
          end else begin
            trunc = 1'b1;
          end
        end
      end
      PH_VALUE: begin
        if (tok.is_cr) begin
          fend = 1'b1; flen_next = '0; phase_next = PH_VAL_LF;
        end else if (tok.is_sp) begin
          kind = KIND_NONE;
        end else if (!extra && fl < FLEN_W'(VALUE_MAX)) begin
          flen_next = fl + FLEN_W'(1);
          kind      = KIND_VALUE;
        end else begin
          trunc = 1'b1;
        end
      end
      PH_DONE, PH_ERROR: begin
        kind = KIND_NONE;
      end
      default: begin
        err_next = 1'b1; phase_next = PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_METHOD;
      flen      <= '0;
      mtot      <= '0;
      hnum      <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase <= phase_next;
        flen  <= flen_next;
        mtot  <= mtot_next;
        hnum  <= hnum_next;
        err   <= err_next;
      end
      if (tok_ready) begin
        out_valid <= tok_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      field_kind   <= kind;
      out_byte     <= obyte;
      field_end    <= fend;
      header_index <= 6'(hnum_next);
      method_sum   <= mtot_next;
      truncated    <= trunc;
      status       <= err_next ? ST_ERROR :
                      (phase_next == PH_DONE ? ST_DONE : ST_BUSY);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ERROR) |-> (field_kind == KIND_NONE && !field_end))
    else $error("byte kept after malformed line end");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (truncated || field_end)) |-> field_kind == KIND_NONE)
    else $error("dropped or delimiter byte tagged as field data");
  assert property (@(posedge clk) disable iff (rst)
    (pop && !tok.start && err) |=> err)
    else $error("error flag cleared without a new request");
  assert property (@(posedge clk) disable iff (rst)
    (err == (phase == PH_ERROR)))
    else $error("error flag and parse phase disagree");

endmodule

// ===== rtl/http_request_header_tokenizer.sv =====
// ---------------------------------------------------------------------------
// http_request_header_tokenizer
// Tags each request byte with its field, lowercases header names and tracks
// method sum, header count and line-end errors.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid/in_ready    data_byte, start_request
//  output   out_valid/out_ready  field_kind, out_byte, field_end,
//                                header_index, method_sum, truncated, status
//
//  One byte per cycle sustained while the output is not stalled; each byte
//  passes the classify register, two-entry queue and parser output register.
//  The parser computes its next state combinationally from one token.
//  Synchronous reset puts the parser in the method field and empties the queue.
//  Output stalls fill the queue, then hold off the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_header_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  field_kind,
  output logic [7:0]  out_byte,
  output logic        field_end,
  output logic [5:0]  header_index,
  output logic [11:0] method_sum,
  output logic        truncated,
  output logic [1:0]  status
);
  import htok_pkg::*;

  logic   f_valid, f_ready;
  token_t f_tok;
  logic   q_valid, q_ready;
  token_t q_tok;

  htok_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_request (start_request),
    .tok_valid     (f_valid),
    .tok_ready     (f_ready),
    .tok           (f_tok)
  );

  htok_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_tok   (f_tok),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_tok   (q_tok)
  );

  htok_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (q_valid),
    .tok_ready    (q_ready),
    .tok          (q_tok),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .field_kind   (field_kind),
    .out_byte     (out_byte),
    .field_end    (field_end),
    .header_index (header_index),
    .method_sum   (method_sum),
    .truncated    (truncated),
    .status       (status)
  );

endmodule

// ===== test/http_request_header_tokenizer_test.sv =====
// ---------------------------------------------------------------------------
// http_request_header_tokenizer_test
// Feeds request bytes through the tokenizer under random input gaps and
// output stalls. A scoreboard tracks parse phase, field lengths, method sum,
// header count and line-end errors, and checks every output word against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_header_tokenizer_test;
  import htok_pkg::*;

  localparam int BYTE_BUDGET     = 600;
  localparam int STUCK_LIMIT     = 1000;
  localparam int SHAPE_PLAIN     = 0;
  localparam int SHAPE_LONG_URI  = 1;
  localparam int SHAPE_LONG_VAL  = 2;
  localparam int SHAPE_CROWDED   = 3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  obyte;
    logic        fend;
    logic [5:0]  hidx;
    logic [11:0] msum;
    logic        trunc;
    logic [1:0]  stat;
  } token_rec_t;

  class token_ledger;
    logic [3:0]  phase;
    logic [8:0]  flen;
    logic [11:0] msum;
    logic [5:0]  hnum;
    logic        err;
    token_rec_t  due[$];
    int          faults;

    function new();
      clear_request();
      faults = 0;
    endfunction

    function void clear_request();
      phase = PH_METHOD;
      flen  = '0;
      msum  = '0;
      hnum  = '0;
      err   = 1'b0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void log_byte(logic [7:0] b, logic st);
      token_rec_t t;
      logic [12:0] wide;
      logic crowded;
      if (st) clear_request();
      t.kind  = KIND_NONE;
      t.obyte = b;
      t.fend  = 1'b0;
      t.trunc = 1'b0;
      crowded = (hnum >= HEADERS_MAX);
      case (phase)
        PH_METHOD: begin
          if (b == CH_SP) begin
            t.fend = 1'b1; flen = '0; phase = PH_URI;
          end else if (flen < METHOD_MAX) begin
            flen++;
            t.kind = KIND_METHOD;
            wide = {1'b0, msum} + b;
            msum = (wide > 13'd4095) ? 12'hFFF : wide[11:0];
          end else begin
            t.trunc = 1'b1;
          end
        end
        PH_URI: begin
          if (b == CH_SP) begin
            t.fend = 1'b1; flen = '0; phase = PH_VERSION;
          end else if (flen < URI_MAX) begin
            flen++; t.kind = KIND_URI;
          end else begin
            t.trunc = 1'b1;
          end
        end
        PH_VERSION: begin
          if (b == CH_CR) begin
            t.fend = 1'b1; flen = '0; phase = PH_VER_LF;
          end else if (flen < VERSION_MAX) begin
            flen++; t.kind = KIND_VERSION;
          end else begin
            t.trunc = 1'b1;
          end
        end
        PH_VER_LF, PH_VAL_LF, PH_END_LF: begin
          if (b != CH_LF) begin
            err = 1'b1; phase = PH_ERROR;
          end else if (phase == PH_END_LF) begin
            phase = PH_DONE;
          end else begin
            if (phase == PH_VAL_LF && hnum < HEADERS_MAX) hnum++;
            flen = '0; phase = PH_LINE;
          end
        end
        PH_LINE, PH_NAME: begin
          if (phase == PH_LINE && b == CH_CR) begin
            phase = PH_END_LF;
          end else begin
            phase = PH_NAME;
            if (b == CH_COLON) begin
              t.fend = 1'b1; flen = '0; phase = PH_VALUE;
            end else if (b == CH_CR) begin
              t.fend = 1'b1; flen = '0; phase = PH_VAL_LF;
            end else if (!crowded && flen < NAME_MAX) begin
              flen++;
              t.kind = KIND_NAME;
              if (b > CH_UPPER_LO && b < CH_UPPER_HI) t.obyte = b + CH_CASE_OFS;
            end else begin
              t.trunc = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          if (b == CH_CR) begin
            t.fend = 1'b1; flen = '0; phase = PH_VAL_LF;
          end else if (b == CH_SP) begin
            // drop spaces without flagging
          end else if (!crowded && flen < VALUE_MAX) begin
            flen++; t.kind = KIND_VALUE;
          end else begin
            t.trunc = 1'b1;
          end
        end
        PH_DONE, PH_ERROR: begin
        end
        default: begin
          err = 1'b1; phase = PH_ERROR;
        end
      endcase
      t.hidx = hnum;
      t.msum = msum;
      t.stat = err ? ST_ERROR : (phase == PH_DONE ? ST_DONE : ST_BUSY);
      due.push_back(t);
    endfunction

    function void compare_field(string label, int want, int got);
      if (want != got) begin
        faults++;
        $display("%0t %s mismatch: expected %0d, got %0d", $time, label, want, got);
      end
    endfunction

    function void match_token(token_rec_t got);
      token_rec_t want;
      if (due.size() == 0) begin
        faults++;
        $display("%0t unexpected word: expected none, got %h", $time, got);
        return;
      end
      want = due.pop_front();
      compare_field("field_kind", want.kind, got.kind);
      compare_field("out_byte", want.obyte, got.obyte);
      compare_field("field_end", want.fend, got.fend);
      compare_field("header_index", want.hidx, got.hidx);
      compare_field("method_sum", want.msum, got.msum);
      compare_field("truncated", want.trunc, got.trunc);
      compare_field("status", want.stat, got.stat);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        start_request = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  field_kind;
  logic [7:0]  out_byte;
  logic        field_end;
  logic [5:0]  header_index;
  logic [11:0] method_sum;
  logic        truncated;
  logic [1:0]  status;

  token_ledger ledger;
  logic [7:0]  frame[$];
  int          bytes_fed = 0;
  int          stuck_cycles = 0;
  bit          calm = 1'b0;
  bit          jam = 1'b0;

  http_request_header_tokenizer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .start_request(start_request),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .field_kind(field_kind),
    .out_byte(out_byte),
    .field_end(field_end),
    .header_index(header_index),
    .method_sum(method_sum),
    .truncated(truncated),
    .status(status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] any_byte_but(logic [7:0] x, logic [7:0] y);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == x || b == y) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] letter();
    logic [7:0] ofs;
    ofs = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? 8'("A") + ofs : 8'("a") + ofs;
  endfunction

  function automatic logic [7:0] name_byte();
    case ($urandom_range(0, 9))
      0: return any_byte_but(CH_COLON, CH_CR);
      1: return CH_UPPER_LO;
      2: return CH_UPPER_HI;
      3: return 8'("-");
      default: return letter();
    endcase
  endfunction

  function automatic void add_line_end(bit may_break);
    frame.push_back(CH_CR);
    if (may_break && $urandom_range(0, 39) == 0) frame.push_back(any_byte_but(CH_LF, CH_LF));
    else frame.push_back(CH_LF);
  endfunction

  function automatic void build_request(int shape);
    int n;
    int hdrs;
    bit wild;
    frame.delete();
    wild = (shape == SHAPE_PLAIN);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(METHOD_MAX + 1, METHOD_MAX + 3)
                                    : $urandom_range(1, 7);
    repeat (n) frame.push_back($urandom_range(0, 3) == 0 ? any_byte_but(CH_SP, CH_SP) : letter());
    frame.push_back(CH_SP);
    n = (shape == SHAPE_LONG_URI) ? URI_MAX + 2 : $urandom_range(0, 12);
    repeat (n) frame.push_back(any_byte_but(CH_SP, CH_SP));
    frame.push_back(CH_SP);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(VERSION_MAX + 1, VERSION_MAX + 2)
                                    : $urandom_range(0, 8);
    repeat (n) frame.push_back(any_byte_but(CH_CR, CH_CR));
    add_line_end(wild);
    hdrs = (shape == SHAPE_CROWDED) ? HEADERS_MAX + 2 : $urandom_range(0, 4);
    for (int h = 0; h < hdrs; h++) begin
      if (shape == SHAPE_CROWDED) n = $urandom_range(1, 2);
      else if ($urandom_range(0, 11) == 0) n = $urandom_range(NAME_MAX + 1, NAME_MAX + 2);
      else n = $urandom_range(0, 8);
      repeat (n) frame.push_back(name_byte());
      if ($urandom_range(0, 5) == 0) begin
        add_line_end(wild);
      end else begin
        frame.push_back(CH_COLON);
        if (shape == SHAPE_LONG_VAL && h == 0) n = VALUE_MAX + 3;
        else n = (shape == SHAPE_CROWDED) ? $urandom_range(0, 1) : $urandom_range(0, 10);
        repeat (n) frame.push_back($urandom_range(0, 3) == 0 ? CH_SP : any_byte_but(CH_CR, CH_CR));
        add_line_end(wild);
      end
    end
    add_line_end(wild);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(0, 255)));
    if (wild && $urandom_range(0, 11) == 0) begin
      n = $urandom_range(1, frame.size());
      frame = frame[0:n-1];
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic st);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    start_request <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.log_byte(b, st);
    bytes_fed++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame[i]) push_byte(frame[i], i == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (jam) begin
        hold = 60;
        jam = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.match_token({field_kind, out_byte, field_end, header_index, method_sum,
                          truncated, status});
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int req;
    int shape;
    ledger = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // empty URI and version, empty header section, byte after completion
    frame = {8'hFF, 8'h00, CH_SP, CH_SP, CH_CR, CH_LF, CH_CR, CH_LF, 8'("x")};
    send_frame();
    // uppercase name, spaced value, CR inside a name, broken final line end
    frame = {8'("P"), CH_SP, 8'("/"), CH_SP, 8'("V"), CH_CR, CH_LF,
             8'("Z"), CH_UPPER_LO, CH_COLON, CH_SP, 8'("y"), CH_CR, CH_LF,
             8'("Q"), CH_CR, CH_LF, CH_CR, 8'("Z")};
    send_frame();
    drain();

    req = 0;
    while (bytes_fed < BYTE_BUDGET || req < 3) begin
      case (req)
        0: shape = SHAPE_CROWDED;
        1: shape = SHAPE_LONG_URI;
        2: shape = SHAPE_LONG_VAL;
        default: shape = SHAPE_PLAIN;
      endcase
      if (req == 0) jam = 1'b1;
      if (req == 2) drain();
      if (req >= 3 && $urandom_range(0, 11) == 0) begin
        frame.delete();
        repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_request(shape);
      end
      if (bytes_fed >= BYTE_BUDGET - 150) calm = 1'b1;
      send_frame();
      req++;
    end

    drain();
    repeat (8) @(negedge clk);
    if (ledger.faults == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
